// File: rtl/kbr_pkg.sv
// Shared types and constants for the keyboard report builder.
// Depends on nothing; every other file refers to it by scoped names.
package kbr_pkg;

	// Keys carried in one boot report
	localparam int REPORT_KEYS = 6;

	// Entries of the command queue between front and back
	localparam int CMD_DEPTH = 2;

	// Operation codes of an input item
	typedef enum logic [2:0] {
		OP_PRESS    = 3'd0,
		OP_RELEASE  = 3'd1,
		OP_MODIFY   = 3'd2,
		OP_UNMODIFY = 3'd3,
		OP_ONESHOT  = 3'd4,
		OP_TICK     = 3'd5
	} kbr_op_t;

	// Classified command handed from the front to the back
	typedef struct packed {
		kbr_op_t    op;
		logic [7:0] arg;     // key code or modifier mask
		logic       accept;  // host takes the front report (tick only)
	} cmd_t;

	// One queued report: modifier byte and six key codes
	typedef struct packed {
		logic [7:0]                  mods;
		logic [REPORT_KEYS-1:0][7:0] keys;
	} report_t;

	// Sequencer of the back end
	typedef enum logic [1:0] {
		BK_RUN,
		BK_READ,
		BK_EMIT
	} back_state_t;

endpackage

// File: rtl/kbr_front.sv
// Front end: takes input transfers, drops unused codes and classifies the rest.
// Depends on kbr_pkg for the operation codes and the command struct.
module kbr_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [2:0]    operation,
	input  logic [7:0]    key_code,
	input  logic [7:0]    mod_bits,
	input  logic          host_accepts,
	output logic          push_valid,
	input  logic          push_ready,
	output kbr_pkg::cmd_t push_cmd
);

	logic          valid_s1;
	kbr_pkg::cmd_t cmd_s1;
	logic          known;
	kbr_pkg::cmd_t cmd_d;

	// Classify the incoming item and pick its argument
	always_comb begin
		known         = 1'b1;
		cmd_d.op      = kbr_pkg::OP_TICK;
		cmd_d.arg     = mod_bits;
		cmd_d.accept  = host_accepts;
		unique case (operation)
			kbr_pkg::OP_PRESS: begin
				cmd_d.op  = kbr_pkg::OP_PRESS;
				cmd_d.arg = key_code;
			end
			kbr_pkg::OP_RELEASE: begin
				cmd_d.op  = kbr_pkg::OP_RELEASE;
				cmd_d.arg = key_code;
			end
			kbr_pkg::OP_MODIFY:   cmd_d.op = kbr_pkg::OP_MODIFY;
			kbr_pkg::OP_UNMODIFY: cmd_d.op = kbr_pkg::OP_UNMODIFY;
			kbr_pkg::OP_ONESHOT:  cmd_d.op = kbr_pkg::OP_ONESHOT;
			kbr_pkg::OP_TICK:     cmd_d.op = kbr_pkg::OP_TICK;
			default:              known    = 1'b0;
		endcase
	end

	// Advance the stage whenever it is empty or its command moves on
	assign in_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid && known;
		end
	end

	// Hold the classified command
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			cmd_s1 <= cmd_d;
		end
	end

	assign push_valid = valid_s1;
	assign push_cmd   = cmd_s1;

endmodule

// File: rtl/kbr_cmd_queue.sv
// Short command queue that decouples the front end from the back end.
// Depends on kbr_pkg for the command struct and the queue depth.
module kbr_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  kbr_pkg::cmd_t push_cmd,
	output logic          pop_valid,
	input  logic          pop,
	output kbr_pkg::cmd_t pop_cmd
);

	localparam int PW = (kbr_pkg::CMD_DEPTH > 1) ? $clog2(kbr_pkg::CMD_DEPTH) : 1;
	localparam int CW = $clog2(kbr_pkg::CMD_DEPTH + 1);

	kbr_pkg::cmd_t  entry_q [kbr_pkg::CMD_DEPTH];
	logic [PW-1:0]  wr_ptr_q;
	logic [PW-1:0]  rd_ptr_q;
	logic [CW-1:0]  count_q;
	logic           do_push;
	logic           do_pop;

	assign push_ready = count_q != CW'(kbr_pkg::CMD_DEPTH);
	assign pop_valid  = count_q != '0;
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = entry_q[rd_ptr_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(kbr_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(kbr_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store the pushed command
	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/kbr_back.sv
// Back end: sorted key set, modifier state, report memory and output register.
// Depends on kbr_pkg for commands, report layout and sequencer states.
module kbr_back #(
	parameter int KEY_SLOTS   = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  kbr_pkg::cmd_t    cmd,
	output logic             cmd_pop,
	output logic             out_valid,
	input  logic             out_ready,
	output kbr_pkg::report_t out_report,
	output logic             out_popped,
	output logic             out_lost
);

	localparam int CW = $clog2(KEY_SLOTS + 1);
	localparam int HW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FW = $clog2(QUEUE_DEPTH + 1);
	localparam int SW = FW + 1;

	// Key set and modifier state
	logic [7:0]    keys_q [KEY_SLOTS];
	logic [CW-1:0] count_q;
	logic [7:0]    held_mods_q;
	logic [7:0]    oneshot_q;
	logic          changed_q;
	logic          lost_q;

	// Report memory
	kbr_pkg::report_t mem_q [QUEUE_DEPTH];
	kbr_pkg::report_t rd_data_q;
	logic [HW-1:0]    head_q;
	logic [FW-1:0]    fill_q;
	logic             accept_q;

	// Output register
	logic             out_valid_q;
	kbr_pkg::report_t out_report_q;
	logic             out_popped_q;
	logic             out_lost_q;

	kbr_pkg::back_state_t state_q;
	kbr_pkg::back_state_t state_d;

	logic [KEY_SLOTS-1:0] slot_valid;
	logic [KEY_SLOTS-1:0] slot_lt;
	logic [KEY_SLOTS-1:0] slot_hit;
	logic [KEY_SLOTS-1:0] slot_ge;
	logic [7:0]           ins_keys [KEY_SLOTS];
	logic [7:0]           del_keys [KEY_SLOTS];
	logic                 key_hit;
	logic                 set_full;
	logic                 fifo_full;
	logic [SW-1:0]        tail_sum;
	logic [HW-1:0]        tail;
	logic [HW-1:0]        head_next;
	kbr_pkg::report_t     snap;
	logic                 is_tick;
	logic                 snap_wr;
	logic                 tick_has_report;
	logic                 exec_en;
	logic                 emit_en;
	logic                 out_free;

	// Compare every slot against the command argument
	for (genvar i = 0; i < KEY_SLOTS; i++) begin : g_slot
		assign slot_valid[i] = count_q > CW'(i);
		assign slot_lt[i]    = slot_valid[i] && (keys_q[i] < cmd.arg);
		assign slot_hit[i]   = slot_valid[i] && (keys_q[i] == cmd.arg);
		assign slot_ge[i]    = slot_valid[i] && !(keys_q[i] < cmd.arg);
		if (i == 0) begin : g_first
			assign ins_keys[i] = slot_lt[i] ? keys_q[i] : cmd.arg;
		end else begin : g_rest
			assign ins_keys[i] = slot_lt[i] ? keys_q[i] :
			                     (slot_lt[i-1] ? cmd.arg : keys_q[i-1]);
		end
		if (i == KEY_SLOTS - 1) begin : g_last
			assign del_keys[i] = keys_q[i];
		end else begin : g_inner
			assign del_keys[i] = slot_ge[i] ? keys_q[i+1] : keys_q[i];
		end
	end

	assign key_hit  = |slot_hit;
	assign set_full = count_q == CW'(KEY_SLOTS);

	// Build the snapshot from the lowest held keys
	always_comb begin
		snap.mods = held_mods_q | oneshot_q;
		for (int j = 0; j < kbr_pkg::REPORT_KEYS; j++) begin
			snap.keys[j] = slot_valid[j] ? keys_q[j] : 8'h00;
		end
	end

	// Queue addressing
	assign fifo_full = fill_q == FW'(QUEUE_DEPTH);
	assign tail_sum  = SW'(head_q) + SW'(fill_q);
	assign tail      = (tail_sum >= SW'(QUEUE_DEPTH)) ? HW'(tail_sum - SW'(QUEUE_DEPTH))
	                                                  : HW'(tail_sum);
	assign head_next = (head_q == HW'(QUEUE_DEPTH - 1)) ? '0 : head_q + 1'b1;

	assign out_free        = !out_valid_q || out_ready;
	assign is_tick         = cmd.op == kbr_pkg::OP_TICK;
	assign snap_wr         = exec_en && is_tick && changed_q && !fifo_full;
	assign tick_has_report = (fill_q != '0) || (changed_q && !fifo_full);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			kbr_pkg::BK_RUN: begin
				if (cmd_valid && is_tick && tick_has_report) begin
					state_d = kbr_pkg::BK_READ;
				end
			end
			kbr_pkg::BK_READ: state_d = kbr_pkg::BK_EMIT;
			kbr_pkg::BK_EMIT: begin
				if (out_free) begin
					state_d = kbr_pkg::BK_RUN;
				end
			end
			default: state_d = kbr_pkg::BK_RUN;
		endcase
	end

	// Sequencer outputs
	always_comb begin
		exec_en = 1'b0;
		emit_en = 1'b0;
		unique case (state_q)
			kbr_pkg::BK_RUN:  exec_en = cmd_valid;
			kbr_pkg::BK_READ: ;
			kbr_pkg::BK_EMIT: emit_en = out_free;
			default: ;
		endcase
	end

	assign cmd_pop = exec_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kbr_pkg::BK_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// Carry out commands on the control state; release the front report
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			held_mods_q <= '0;
			oneshot_q   <= '0;
			changed_q   <= 1'b0;
			lost_q      <= 1'b0;
			head_q      <= '0;
			fill_q      <= '0;
		end else if (exec_en) begin
			unique case (cmd.op)
				kbr_pkg::OP_PRESS: begin
					if (key_hit) begin
						changed_q <= 1'b1;
					end else if (set_full) begin
						lost_q <= 1'b1;
					end else begin
						count_q   <= count_q + 1'b1;
						changed_q <= 1'b1;
					end
				end
				kbr_pkg::OP_RELEASE: begin
					if (key_hit) begin
						count_q <= count_q - 1'b1;
					end
					changed_q <= 1'b1;
				end
				kbr_pkg::OP_MODIFY: begin
					held_mods_q <= held_mods_q | cmd.arg;
					changed_q   <= 1'b1;
				end
				kbr_pkg::OP_UNMODIFY: begin
					held_mods_q <= held_mods_q & ~cmd.arg;
					changed_q   <= 1'b1;
				end
				kbr_pkg::OP_ONESHOT: oneshot_q <= oneshot_q | cmd.arg;
				kbr_pkg::OP_TICK: begin
					if (changed_q) begin
						if (fifo_full) begin
							lost_q <= 1'b1;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
						oneshot_q <= '0;
						changed_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end else if (emit_en) begin
			lost_q <= 1'b0;
			if (accept_q) begin
				head_q <= head_next;
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Shift the key slots on insertion or removal
	always_ff @(posedge clk) begin
		if (exec_en && cmd.op == kbr_pkg::OP_PRESS && !key_hit && !set_full) begin
			for (int k = 0; k < KEY_SLOTS; k++) begin
				keys_q[k] <= ins_keys[k];
			end
		end else if (exec_en && cmd.op == kbr_pkg::OP_RELEASE && key_hit) begin
			for (int k = 0; k < KEY_SLOTS; k++) begin
				keys_q[k] <= del_keys[k];
			end
		end
	end

	// Report memory: write the snapshot, read the head every cycle
	always_ff @(posedge clk) begin
		if (snap_wr) begin
			mem_q[tail] <= snap;
		end
		rd_data_q <= mem_q[head_q];
	end

	// Hold the host decision of the tick in progress
	always_ff @(posedge clk) begin
		if (exec_en && is_tick) begin
			accept_q <= cmd.accept;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_en) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			out_report_q <= rd_data_q;
			out_popped_q <= accept_q;
			out_lost_q   <= lost_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_report = out_report_q;
	assign out_popped = out_popped_q;
	assign out_lost   = out_lost_q;

	// Checks
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FW'(QUEUE_DEPTH))
		else $error("report queue over-filled");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(KEY_SLOTS))
		else $error("key set over-filled");

	a_emit_from_seq: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == kbr_pkg::BK_EMIT)
		else $error("result loaded outside the emit step");

	a_pop_drains: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en && accept_q |=> fill_q == $past(fill_q) - 1'b1)
		else $error("accepted report not removed");

	for (genvar s = 1; s < KEY_SLOTS; s++) begin : g_sorted
		a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
			count_q > CW'(s) |-> keys_q[s-1] < keys_q[s])
			else $error("held keys out of order");
	end

endmodule

// File: rtl/keyboard_report_builder.sv
// Boot keyboard report builder: front end, command queue and back end.
// Depends on kbr_pkg, kbr_front, kbr_cmd_queue and kbr_back.
//
// Input channel (in_valid/in_ready) carries press, release, modify,
// unmodify, oneshot and tick items; codes six and seven are taken and
// dropped. Output channel (out_valid/out_ready) carries one report per tick
// that finds the report queue non-empty (after any snapshot of that tick).
// A front stage registers and classifies each transfer, a two-entry command
// queue lets the front keep taking items while the back is busy, and the
// back edits the sorted key set with parallel slot compares.
// Non-tick items stream at one per cycle while the back is in its run
// step. A tick goes through the back-end steps execute with snapshot write,
// report memory read and load of the output register.
// Reset clears the key count, modifiers, flags, queue pointers and all
// valid state; no clearing pass is needed. When the receiver stalls, the
// output register holds its report, the back waits in its emit step, and
// the command queue and front stage fill before in_ready falls.
module keyboard_report_builder #(
	parameter int KEY_SLOTS   = 16,
	parameter int QUEUE_DEPTH = 8
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] operation,
	input  logic [7:0] key_code,
	input  logic [7:0] mod_bits,
	input  logic       host_accepts,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] report_mods,
	output logic [7:0] key_slot_0,
	output logic [7:0] key_slot_1,
	output logic [7:0] key_slot_2,
	output logic [7:0] key_slot_3,
	output logic [7:0] key_slot_4,
	output logic [7:0] key_slot_5,
	output logic       report_popped,
	output logic       lost_flag
);

	logic             push_valid;
	logic             push_ready;
	kbr_pkg::cmd_t    push_cmd;
	logic             cmd_valid;
	logic             cmd_pop;
	kbr_pkg::cmd_t    cmd;
	kbr_pkg::report_t report;

	kbr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.key_code     (key_code),
		.mod_bits     (mod_bits),
		.host_accepts (host_accepts),
		.push_valid   (push_valid),
		.push_ready   (push_ready),
		.push_cmd     (push_cmd)
	);

	kbr_cmd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_cmd   (push_cmd),
		.pop_valid  (cmd_valid),
		.pop        (cmd_pop),
		.pop_cmd    (cmd)
	);

	kbr_back #(
		.KEY_SLOTS   (KEY_SLOTS),
		.QUEUE_DEPTH (QUEUE_DEPTH)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_report (report),
		.out_popped (report_popped),
		.out_lost   (lost_flag)
	);

	// Unpack the report into its byte fields
	assign report_mods = report.mods;
	assign key_slot_0  = report.keys[0];
	assign key_slot_1  = report.keys[1];
	assign key_slot_2  = report.keys[2];
	assign key_slot_3  = report.keys[3];
	assign key_slot_4  = report.keys[4];
	assign key_slot_5  = report.keys[5];

endmodule
